// ===== rtl/c1sc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and functions for the Crypto1 stream cipher unit.
// No dependencies; imported by every other file of the block.
package c1sc_pkg;

   localparam int DATA_W     = 32;
   localparam int HALF_W     = 24;
   localparam int KEY_W      = 48;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;
   localparam int CNT_W      = 5;

   // Opcodes
   localparam logic [2:0] OP_LOAD = 3'd0;
   localparam logic [2:0] OP_BIT  = 3'd1;
   localparam logic [2:0] OP_BYTE = 3'd2;
   localparam logic [2:0] OP_WORD = 3'd3;
   localparam logic [2:0] OP_PEEK = 3'd4;

   // Register index
   localparam logic REG_CIPHER_KEY = 1'b0;

   // LFSR feedback taps
   localparam logic [HALF_W-1:0] TAPS_ODD  = 24'h29CE5C;
   localparam logic [HALF_W-1:0] TAPS_EVEN = 24'h870804;

   // Nonlinear filter tables
   localparam logic [19:0] NLF_A   = 20'hf22c0;
   localparam logic [19:0] NLF_B   = 20'h6c9c0;
   localparam logic [19:0] NLF_C   = 20'h3c8b0;
   localparam logic [19:0] NLF_D   = 20'h1e458;
   localparam logic [19:0] NLF_E   = 20'h0d938;
   localparam logic [31:0] NLF_OUT = 32'hEC57E80A;

   // How the collected keystream is placed in the result
   typedef enum logic [1:0] {
      OUT_ZERO,
      OUT_BIT,
      OUT_BYTE,
      OUT_WORD
   } out_mode_type;

   // Control from the sequencer to the LFSR
   typedef struct packed {
      logic load;
      logic step;
      logic din;
      logic fk;
   } lfsr_ctrl_type;

   // Control from the sequencer to the bit shifters
   typedef struct packed {
      logic capture;
      logic word_order;
      logic peek;
      logic shift;
   } serdes_ctrl_type;

   // Filter function of the odd half
   function automatic logic nlf(input logic [HALF_W-1:0] v);
      logic [19:0] ta;
      logic [19:0] tb;
      logic [19:0] tc;
      logic [19:0] td;
      logic [19:0] te;
      logic [4:0]  sel;
      logic [31:0] tout;
      ta = NLF_A >> v[3:0];
      tb = NLF_B >> v[7:4];
      tc = NLF_C >> v[11:8];
      td = NLF_D >> v[15:12];
      te = NLF_E >> v[19:16];
      sel = {ta[4], tb[3], tc[2], td[1], te[0]};
      tout = NLF_OUT >> sel;
      return tout[0];
   endfunction

   // Byte reversal: bit i of the result is bit (i xor 24) of the input
   function automatic logic [DATA_W-1:0] byte_swap(input logic [DATA_W-1:0] d);
      return {d[7:0], d[15:8], d[23:16], d[31:24]};
   endfunction

   // Key interleave into the odd half
   function automatic logic [HALF_W-1:0] key_odd(input logic [KEY_W-1:0] key);
      logic [HALF_W-1:0] o;
      int k;
      o = '0;
      for (int j = 0; j < HALF_W; j++) begin
         k = KEY_W - 1 - 2 * j;
         o[HALF_W-1-j] = key[(k - 1) ^ 7];
      end
      return o;
   endfunction

   // Key interleave into the even half
   function automatic logic [HALF_W-1:0] key_even(input logic [KEY_W-1:0] key);
      logic [HALF_W-1:0] e;
      int k;
      e = '0;
      for (int j = 0; j < HALF_W; j++) begin
         k = KEY_W - 1 - 2 * j;
         e[HALF_W-1-j] = key[k ^ 7];
      end
      return e;
   endfunction

endpackage

// ===== rtl/crypto1_stream_cipher_unit.sv =====
`timescale 1ns / 1ps
// Crypto1 stream cipher unit: top level with sequencer and key register.
// Depends on c1sc_pkg, c1sc_lfsr and c1sc_serdes.
// Sequence: S_IDLE accepts a request, S_RUN steps the LFSR for each bit of a bit, byte or word
// request, S_FIN registers the result and raises rsp_valid; load, peek and unknown opcodes skip S_RUN.
// Throughput: one transaction at a time; S_FIN waits while an earlier response is not yet taken.
// Reset (synchronous): LFSR halves and key cleared, sequencer idle, no response pending.
module crypto1_stream_cipher_unit
   import c1sc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // Request channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [2:0]              req_opcode,
   input  logic [DATA_W-1:0]       req_data_in,
   input  logic                    req_feed_keystream,
   // Response channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [DATA_W-1:0]       rsp_keystream_out,
   // Configuration port
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_FIN
   } state_type;

   state_type         state_ff;
   out_mode_type      mode_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  last_ff;
   logic              fk_ff;
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [KEY_W-1:0]  key_ff;

   logic              req_fire;
   logic              csr_wr;
   logic              csr_sel_key;
   logic              ks_bit;
   logic              data_bit;
   logic [DATA_W-1:0] result;
   lfsr_ctrl_type     lfsr_ctrl;
   serdes_ctrl_type   serdes_ctrl;

   // Configuration register, 8-byte spacing
   assign csr_pready  = 1'b1;
   assign csr_sel_key = (csr_paddr[3] == REG_CIPHER_KEY);
   assign csr_wr      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata  = csr_sel_key ? {{(CSR_DATA_W-KEY_W){1'b0}}, key_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_wr && csr_sel_key) begin
         key_ff <= csr_pwdata[KEY_W-1:0];
      end
   end

   // Handshakes
   assign req_ready         = (state_ff == S_IDLE);
   assign req_fire          = req_valid & req_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_keystream_out = rsp_data_ff;

   // Datapath control
   always_comb begin
      lfsr_ctrl.load         = req_fire && (req_opcode == OP_LOAD);
      lfsr_ctrl.step         = (state_ff == S_RUN);
      lfsr_ctrl.din          = data_bit;
      lfsr_ctrl.fk           = fk_ff;
      serdes_ctrl.capture    = req_fire;
      serdes_ctrl.word_order = (req_opcode == OP_WORD);
      serdes_ctrl.peek       = (req_opcode == OP_PEEK);
      serdes_ctrl.shift      = (state_ff == S_RUN);
   end

   // Sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= OUT_ZERO;
         cnt_ff       <= '0;
         last_ff      <= '0;
         fk_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // S_FIN sets or holds the response itself
         if (rsp_ready && (state_ff != S_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  fk_ff  <= req_feed_keystream;
                  cnt_ff <= '0;
                  case (req_opcode)
                     OP_BIT: begin
                        mode_ff  <= OUT_BIT;
                        last_ff  <= CNT_W'(0);
                        state_ff <= S_RUN;
                     end
                     OP_BYTE: begin
                        mode_ff  <= OUT_BYTE;
                        last_ff  <= CNT_W'(7);
                        state_ff <= S_RUN;
                     end
                     OP_WORD: begin
                        mode_ff  <= OUT_WORD;
                        last_ff  <= CNT_W'(DATA_W - 1);
                        state_ff <= S_RUN;
                     end
                     OP_PEEK: begin
                        mode_ff  <= OUT_BIT;
                        state_ff <= S_FIN;
                     end
                     default: begin
                        // load and unknown opcodes answer zero
                        mode_ff  <= OUT_ZERO;
                        state_ff <= S_FIN;
                     end
                  endcase
               end
            end
            S_RUN: begin
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == last_ff) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= result;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   c1sc_lfsr u_lfsr (
      .clock  (clock),
      .reset  (reset),
      .key    (key_ff),
      .ctrl   (lfsr_ctrl),
      .ks_bit (ks_bit)
   );

   c1sc_serdes u_serdes (
      .clock    (clock),
      .ctrl     (serdes_ctrl),
      .data_in  (req_data_in),
      .ks_bit   (ks_bit),
      .out_mode (mode_ff),
      .data_bit (data_bit),
      .result   (result)
   );

endmodule

// ===== rtl/c1sc_lfsr.sv =====
`timescale 1ns / 1ps
// 48-bit Crypto1 LFSR held as odd and even halves, one clock per cycle while ctrl.step is set.
// Depends on c1sc_pkg (filter, taps, key interleave, control struct).
module c1sc_lfsr
   import c1sc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [KEY_W-1:0]    key,
   input  lfsr_ctrl_type       ctrl,
   output logic                ks_bit
);

   logic [HALF_W-1:0] odd_ff;
   logic [HALF_W-1:0] even_ff;
   logic [HALF_W-1:0] odd_in;
   logic [HALF_W-1:0] even_in;
   logic              fb;

   // Keystream bit is the filter of the current odd half
   assign ks_bit = nlf(odd_ff);

   // Feedback: input bit, optional keystream, tap parity of both halves
   assign fb = (ks_bit & ctrl.fk) ^ ctrl.din ^ (^(odd_ff & TAPS_ODD))
             ^ (^(even_ff & TAPS_EVEN));

   // Next state: load the interleaved key, or shift feedback into even half, then swap halves
   always_comb begin
      odd_in  = odd_ff;
      even_in = even_ff;
      if (ctrl.load) begin
         odd_in  = key_odd(key);
         even_in = key_even(key);
      end else if (ctrl.step) begin
         odd_in  = {even_ff[HALF_W-2:0], fb};
         even_in = odd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         odd_ff  <= '0;
         even_ff <= '0;
      end else begin
         odd_ff  <= odd_in;
         even_ff <= even_in;
      end
   end

endmodule

// ===== rtl/c1sc_serdes.sv =====
`timescale 1ns / 1ps
// Data-in and keystream shift registers, one bit per cycle while shifting, plus result placement.
// Depends on c1sc_pkg (byte_swap, out_mode_type, serdes_ctrl_type).
module c1sc_serdes
   import c1sc_pkg::*;
(
   input  logic                clock,
   input  serdes_ctrl_type     ctrl,
   input  logic [DATA_W-1:0]   data_in,
   input  logic                ks_bit,
   input  out_mode_type        out_mode,
   output logic                data_bit,
   output logic [DATA_W-1:0]   result
);

   logic [DATA_W-1:0] data_sr_ff;
   logic [DATA_W-1:0] data_sr_in;
   logic [DATA_W-1:0] ks_sr_ff;
   logic [DATA_W-1:0] ks_sr_in;

   assign data_bit = data_sr_ff[0];

   // Capture reorders word data so bits leave LSB first in clocking order
   always_comb begin
      data_sr_in = data_sr_ff;
      ks_sr_in   = ks_sr_ff;
      if (ctrl.capture) begin
         data_sr_in = ctrl.word_order ? byte_swap(data_in) : data_in;
         ks_sr_in   = {ctrl.peek, {(DATA_W-1){1'b0}}} & {DATA_W{ks_bit}};
      end else if (ctrl.shift) begin
         data_sr_in = {1'b0, data_sr_ff[DATA_W-1:1]};
         ks_sr_in   = {ks_bit, ks_sr_ff[DATA_W-1:1]};
      end
   end

   // Payload only, no reset
   always_ff @(posedge clock) begin
      data_sr_ff <= data_sr_in;
      ks_sr_ff   <= ks_sr_in;
   end

   // Keystream enters at the top; align by item size
   always_comb begin
      case (out_mode)
         OUT_BIT:  result = {{(DATA_W-1){1'b0}}, ks_sr_ff[DATA_W-1]};
         OUT_BYTE: result = {{(DATA_W-8){1'b0}}, ks_sr_ff[DATA_W-1:DATA_W-8]};
         OUT_WORD: result = byte_swap(ks_sr_ff);
         default:  result = '0;
      endcase
   end

endmodule
